[design/lovu_pkg.sv]
`default_nettype none

package lovu_pkg;

    // fixed field widths
    localparam int VOXEL_W   = 16;
    localparam int EVENT_W   = 2;
    localparam int LODDS_W   = 14;
    localparam int STEP_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 14;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_STEP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OCCUPIED_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_CLAMP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_CLAMP   = 2'd3;

    // register reset values, Q8.8
    localparam logic signed [STEP_W-1:0]  FREE_STEP_RST     = -13'sd33;
    localparam logic [STEP_W-1:0]         OCCUPIED_STEP_RST = 13'd259;
    localparam logic [STEP_W-1:0]         UPPER_CLAMP_RST   = 13'd896;
    localparam logic signed [LODDS_W-1:0] LOWER_CLAMP_RST   = -14'sd512;

    // event codes
    localparam logic [EVENT_W-1:0] EV_NONE     = 2'd0;
    localparam logic [EVENT_W-1:0] EV_NEW      = 2'd1;
    localparam logic [EVENT_W-1:0] EV_TO_FREE  = 2'd2;
    localparam logic [EVENT_W-1:0] EV_TO_OCCUP = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clr_en;
        logic rd_start;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic out_blocked;
    } dp_status_t;

endpackage

`default_nettype wire

[design/log_odds_voxel_update.sv]
`default_nettype none

// Log-odds occupancy update for a dense voxel map window. Each input transfer
// names a voxel (voxel_addr, taken modulo 2^ADDR_BITS) and whether the ray
// missed (func 0) or hit (func 1) it; each one gives exactly one output
// transfer with the voxel index, the clamped Q8.8 value written back and an
// event code (newly known, occupied to free, free to occupied, or none).
// Each item reads its map memory word (known flag plus value, registered
// read), then adds the step, clamps and writes the word back; no new item
// is taken before that write-back. The output register lets a new item be
// accepted while the previous result waits; the write-back stalls only while
// that register is still full. After reset the block clears all known flags,
// one map entry per cycle, all 2^ADDR_BITS of them (65536 at the default) with
// in_ready low; configuration writes are taken at any time, and are meant to
// be made only while no item is in flight.
module log_odds_voxel_update #(
    parameter int ADDR_BITS  = 16,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [lovu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lovu_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            func,
    input  wire logic [lovu_pkg::VOXEL_W-1:0]    voxel_addr,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [lovu_pkg::VOXEL_W-1:0]    out_addr,
    output logic      [lovu_pkg::EVENT_W-1:0]    event_code,
    output logic signed [lovu_pkg::LODDS_W-1:0] new_log_odds
);

    import lovu_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer
    lovu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // map memory, arithmetic and output register
    lovu_dp #(
        .ADDR_BITS  (ADDR_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .func         (func),
        .voxel_addr   (voxel_addr),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_addr     (out_addr),
        .event_code   (event_code),
        .new_log_odds (new_log_odds)
    );

    // one item in flight: no transfer in the cycle after an accepted one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while an item is in flight");

endmodule

`default_nettype wire

[design/lovu_ram.sv]
`default_nettype none

module lovu_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/lovu_ctrl.sv]
`default_nettype none

module lovu_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire lovu_pkg::dp_status_t status,
    output lovu_pkg::ctrl_cmd_t      cmd
);

    import lovu_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.clr_en   = 1'b0;
        cmd.rd_start = 1'b0;
        cmd.commit   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.rd_start = in_valid;
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // wait for room in the output register
                if (!status.out_blocked)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // no lookup starts while the map is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !cmd.rd_start && !cmd.commit)
        else $error("item work during clearing pass");

endmodule

`default_nettype wire

[design/lovu_dp.sv]
`default_nettype none

module lovu_dp #(
    parameter int ADDR_BITS  = 16,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lovu_pkg::ctrl_cmd_t                 cmd,
    output lovu_pkg::dp_status_t                     status,
    input  wire logic                                cfg_we,
    input  wire logic [lovu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lovu_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                                func,
    input  wire logic [lovu_pkg::VOXEL_W-1:0]        voxel_addr,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [lovu_pkg::VOXEL_W-1:0]        out_addr,
    output logic      [lovu_pkg::EVENT_W-1:0]        event_code,
    output logic signed [lovu_pkg::LODDS_W-1:0]     new_log_odds
);

    import lovu_pkg::*;

    // sum width covers stored value plus step without overflow
    localparam int SUM_W  = ((VALUE_BITS > LODDS_W) ? VALUE_BITS : LODDS_W) + 1;
    localparam int WORD_W = VALUE_BITS + 1;
    localparam int DEPTH  = 1 << ADDR_BITS;

    // configuration registers
    logic signed [STEP_W-1:0]  free_step_reg;
    logic [STEP_W-1:0]         occupied_step_reg;
    logic [STEP_W-1:0]         upper_clamp_reg;
    logic signed [LODDS_W-1:0] lower_clamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_step_reg     <= FREE_STEP_RST;
            occupied_step_reg <= OCCUPIED_STEP_RST;
            upper_clamp_reg   <= UPPER_CLAMP_RST;
            lower_clamp_reg   <= LOWER_CLAMP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FREE_STEP:     free_step_reg     <= cfg_data[STEP_W-1:0];
                CFG_OCCUPIED_STEP: occupied_step_reg <= cfg_data[STEP_W-1:0];
                CFG_UPPER_CLAMP:   upper_clamp_reg   <= cfg_data[STEP_W-1:0];
                CFG_LOWER_CLAMP:   lower_clamp_reg   <= cfg_data;
                default:           free_step_reg     <= free_step_reg;
            endcase
        end
    end

    // clearing pass address counter
    logic [ADDR_BITS-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign status.clr_last = &clr_addr_reg;

    // item capture
    logic [ADDR_BITS-1:0] addr_reg;
    logic                 func_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_start)
        begin
            addr_reg <= ADDR_BITS'(voxel_addr);
            func_reg <= func;
        end
    end

    // map memory: known flag above the log-odds value
    logic [ADDR_BITS-1:0] ram_raddr;
    logic [ADDR_BITS-1:0] ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WORD_W-1:0]    ram_rdata;
    logic                 ram_we;

    logic signed [SUM_W-1:0] new_v;

    assign ram_raddr = cmd.rd_start ? ADDR_BITS'(voxel_addr) : addr_reg;
    assign ram_waddr = cmd.clr_en ? clr_addr_reg : addr_reg;
    assign ram_we    = cmd.clr_en | cmd.commit;
    assign ram_wdata = cmd.clr_en ? '0 : {1'b1, new_v[VALUE_BITS-1:0]};

    lovu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // update arithmetic
    logic                    known;
    logic signed [VALUE_BITS-1:0] stored_v;
    logic signed [SUM_W-1:0] old_v;
    logic signed [SUM_W-1:0] step_v;
    logic signed [SUM_W-1:0] sum_v;
    logic signed [SUM_W-1:0] lo_v;
    logic signed [SUM_W-1:0] hi_v;
    logic signed [SUM_W-1:0] raised_v;
    logic [EVENT_W-1:0]      event_v;

    always_comb
    begin
        known    = ram_rdata[VALUE_BITS];
        stored_v = ram_rdata[VALUE_BITS-1:0];
        old_v    = known ? SUM_W'(stored_v) : '0;
        step_v   = func_reg ? SUM_W'(signed'({1'b0, occupied_step_reg}))
                            : SUM_W'(free_step_reg);
        sum_v    = old_v + step_v;
        lo_v     = SUM_W'(lower_clamp_reg);
        hi_v     = SUM_W'(signed'({1'b0, upper_clamp_reg}));
        // raise to lower bound first, then the upper bound wins
        raised_v = (sum_v < lo_v) ? lo_v : sum_v;
        new_v    = (raised_v > hi_v) ? hi_v : raised_v;
        // zero crossing judged on sign bits
        priority if (!known)
        begin
            event_v = EV_NEW;
        end
        else if (!func_reg && !old_v[SUM_W-1] && new_v[SUM_W-1])
        begin
            event_v = EV_TO_FREE;
        end
        else if (func_reg && old_v[SUM_W-1] && !new_v[SUM_W-1])
        begin
            event_v = EV_TO_OCCUP;
        end
        else
        begin
            event_v = EV_NONE;
        end
    end

    // output register
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [VOXEL_W-1:0]        out_addr_reg;
    logic [EVENT_W-1:0]        event_reg;
    logic signed [LODDS_W-1:0] lodds_reg;

    always_comb
    begin
        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_addr_reg <= VOXEL_W'(addr_reg);
            event_reg    <= event_v;
            lodds_reg    <= new_v[LODDS_W-1:0];
        end
    end

    assign status.out_blocked = out_valid_reg & ~out_ready;
    assign out_valid          = out_valid_reg;
    assign out_addr           = out_addr_reg;
    assign event_code         = event_reg;
    assign new_log_odds       = lodds_reg;

    // a commit always presents a result with the captured address
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg && (out_addr_reg == VOXEL_W'($past(addr_reg))))
        else $error("committed result not presented");

    // a commit never overwrites a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten");

endmodule

`default_nettype wire
